// File: src/cas_pkg.sv
// shared types, constants and arithmetic helpers of the contrast adaptive sharpener
package cas_pkg;

    localparam int PIX_W = 32;
    localparam int CH_W = 8;
    localparam int ROW_W = 12;
    localparam int HGT_W = 13;
    localparam int SHARP_W = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_HEIGHT = 4096;

    // floor(x / 1000) for x below 256000 as (x * LUMA_RECIP) >> 28
    localparam logic [18:0] LUMA_RECIP = 19'd268436;
    // floor(t / 255) for t below 2^21 as (t * DIV255_RECIP) >> 29
    localparam logic [21:0] DIV255_RECIP = 22'd2105377;
    // offset that keeps the scaled product positive before the divide by 255
    localparam logic signed [21:0] DIV_OFFSET = 22'sd1044480;
    localparam logic [13:0] DIV_BIAS = 14'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_SHARPNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_LEFT,
        CAP_MID,
        CAP_RIGHT
    } cas_cap_t;

    typedef struct packed {
        logic       wr_en;
        logic [1:0] wr_slot;
        logic       rd_en;
        cas_cap_t   cap;
        logic [1:0] out_slot;
        logic       step_mul1;
        logic       step_mul2;
        logic       step_div1;
        logic       step_div2;
        logic       sharp_en;
        logic       load_out;
        logic       frame_end;
    } cas_cmd_t;

    typedef struct packed {
        logic out_free;
    } cas_status_t;

    function automatic logic [7:0] luma(input logic [PIX_W-1:0] px);
        logic [17:0] s;
        logic [36:0] p;
        s = 18'(18'(px[7:0]) * 18'd299 + 18'(px[15:8]) * 18'd587 + 18'(px[23:16]) * 18'd114);
        p = 37'(s) * 37'(LUMA_RECIP);
        return p[35:28];
    endfunction

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: src/cas_ram.sv
// generic single write port, single read port ram with registered read
module cas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/cas_ctrl.sv
// controller: configuration, raster counters, pending count and sequencing fsm
module cas_ctrl
    import cas_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int PW = $clog2(MAX_WIDTH + 3)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_kind,
    output logic                  s_ready,
    input  cas_status_t           status,
    output cas_cmd_t              cmd,
    output logic [CW-1:0]         wr_addr,
    output logic [CW-1:0]         rd_addr,
    output logic [SHARP_W-1:0]    sharpness
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_L,
        ST_RD_C,
        ST_RD_R,
        ST_CAP_R,
        ST_MUL1,
        ST_MUL2,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [SHARP_W-1:0]   sharp_reg, sharp_next;
    logic [SHARP_W-1:0]   fw_reg, fw_next;
    logic [HGT_W-1:0]     fh_reg, fh_next;
    logic [CW-1:0]        in_col_reg, in_col_next;
    logic [ROW_W-1:0]     in_row_reg, in_row_next;
    logic [1:0]           in_slot_reg, in_slot_next;
    logic [CW-1:0]        out_col_reg, out_col_next;
    logic [ROW_W-1:0]     out_row_reg, out_row_next;
    logic [1:0]           out_slot_reg, out_slot_next;
    logic [PW-1:0]        pending_reg, pending_next;
    logic                 allow_reg, allow_next;

    logic [WW-1:0]        eff_w;
    logic [HGT_W-1:0]     eff_h;
    logic                 accept;
    logic                 in_wrap, in_last_row, out_wrap, out_last_row, interior;

    always_comb begin
        if (fw_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(fw_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(fw_reg);
        end
        if (fh_reg == '0) begin
            eff_h = HGT_W'(1);
        end else if (32'(fh_reg) > MAX_HEIGHT) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = fh_reg;
        end
    end

    assign accept = s_valid && (state_reg == ST_IDLE);
    assign in_wrap = (32'(in_col_reg) + 1 >= 32'(eff_w));
    assign in_last_row = (32'(in_row_reg) + 1 >= 32'(eff_h));
    assign out_wrap = (32'(out_col_reg) + 1 >= 32'(eff_w));
    assign out_last_row = (32'(out_row_reg) + 1 >= 32'(eff_h));
    assign interior = (out_row_reg != '0) && !out_last_row && (out_col_reg != '0) && !out_wrap;

    always_comb begin
        state_next = state_reg;
        sharp_next = sharp_reg;
        fw_next = fw_reg;
        fh_next = fh_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        in_slot_next = in_slot_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_slot_next = out_slot_reg;
        pending_next = pending_reg;
        allow_next = allow_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SHARPNESS:    sharp_next = cfg_data[SHARP_W-1:0];
                CFG_FRAME_WIDTH:  fw_next = cfg_data[SHARP_W-1:0];
                CFG_FRAME_HEIGHT: fh_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_kind) begin
                        if (in_wrap) begin
                            in_col_next = '0;
                            in_slot_next = (in_slot_reg == 2'd2) ? 2'd0 : in_slot_reg + 2'd1;
                            in_row_next = in_last_row ? '0 : in_row_reg + 1'b1;
                        end else begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                        pending_next = pending_reg + 1'b1;
                        if (32'(pending_reg) > 32'(eff_w)) begin
                            state_next = ST_RD_L;
                            allow_next = 1'b1;
                        end
                    end else if (pending_reg != '0) begin
                        state_next = ST_RD_L;
                        allow_next = 1'b0;
                    end
                end
            end
            ST_RD_L:  state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_RD_R;
            ST_RD_R:  state_next = ST_CAP_R;
            ST_CAP_R: state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_DIV1;
            ST_DIV1:  state_next = ST_DIV2;
            ST_DIV2:  state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    if (out_wrap) begin
                        out_col_next = '0;
                        out_slot_next = (out_slot_reg == 2'd2) ? 2'd0 : out_slot_reg + 2'd1;
                        out_row_next = out_last_row ? '0 : out_row_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    pending_next = pending_reg - 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sharp_reg <= '0;
            fw_reg <= SHARP_W'(1920);
            fh_reg <= HGT_W'(1080);
            in_col_reg <= '0;
            in_row_reg <= '0;
            in_slot_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_slot_reg <= '0;
            pending_reg <= '0;
            allow_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sharp_reg <= sharp_next;
            fw_reg <= fw_next;
            fh_reg <= fh_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            in_slot_reg <= in_slot_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_slot_reg <= out_slot_next;
            pending_reg <= pending_next;
            allow_reg <= allow_next;
        end
    end

    always_comb begin
        cmd = '0;
        cmd.wr_en = accept && !s_kind;
        cmd.wr_slot = in_slot_reg;
        cmd.out_slot = out_slot_reg;
        cmd.rd_en = (state_reg == ST_RD_L) || (state_reg == ST_RD_C) || (state_reg == ST_RD_R);
        unique case (state_reg)
            ST_RD_C:  cmd.cap = CAP_LEFT;
            ST_RD_R:  cmd.cap = CAP_MID;
            ST_CAP_R: cmd.cap = CAP_RIGHT;
            default:  cmd.cap = CAP_NONE;
        endcase
        cmd.step_mul1 = (state_reg == ST_MUL1);
        cmd.step_mul2 = (state_reg == ST_MUL2);
        cmd.step_div1 = (state_reg == ST_DIV1);
        cmd.step_div2 = (state_reg == ST_DIV2);
        cmd.sharp_en = allow_reg && interior && (sharp_reg != '0);
        cmd.load_out = (state_reg == ST_OUT) && status.out_free;
        cmd.frame_end = out_last_row && out_wrap;
    end

    always_comb begin
        unique case (state_reg)
            ST_RD_L: rd_addr = (out_col_reg == '0) ? CW'(MAX_WIDTH - 1) : out_col_reg - 1'b1;
            ST_RD_R: rd_addr = (32'(out_col_reg) == MAX_WIDTH - 1) ? '0 : out_col_reg + 1'b1;
            default: rd_addr = out_col_reg;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign wr_addr = in_col_reg;
    assign sharpness = sharp_reg;

    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while output register busy");
    a_quiet_pixel_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_kind && (32'(pending_reg) <= 32'(eff_w))) |=> (state_reg == ST_IDLE))
        else $error("pixel without result left idle");
    a_slots_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_slot_reg != 2'd3) && (out_slot_reg != 2'd3))
        else $error("ring slot out of range");
    a_emit_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (pending_reg == $past(pending_reg) - 1'b1))
        else $error("pending count not decremented on result");

endmodule

// File: src/cas_datapath.sv
// datapath: three row stores, neighborhood statistics, gain arithmetic and output register
module cas_datapath
    import cas_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cas_cmd_t           cmd,
    output cas_status_t        status,
    input  logic [CW-1:0]      wr_addr,
    input  logic [CW-1:0]      rd_addr,
    input  logic [PIX_W-1:0]   wr_data,
    input  logic [SHARP_W-1:0] sharpness,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [PIX_W-1:0]   m_data,
    output logic               m_last
);

    logic [PIX_W-1:0] rd0, rd1, rd2;
    logic [PIX_W-1:0] px_above, px_mid, px_below;
    logic [7:0]       l_a, l_m, l_b;
    logic [10:0]      sum_reg;
    logic [7:0]       min_reg, max_reg, center_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [19:0]      m1_reg;
    logic signed [11:0] diff_reg;
    logic signed [31:0] num_reg;
    logic [42:0]      prod_reg;
    logic signed [13:0] delta_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;

    logic [7:0]       contrast;
    logic signed [12:0] diff_wide;
    logic signed [20:0] q1;
    logic signed [21:0] t_s;
    logic [13:0]      q;
    logic [7:0]       ch_out [3];

    cas_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram0 (
        .aclk(aclk), .we(cmd.wr_en && (cmd.wr_slot == 2'd0)), .waddr(wr_addr), .wdata(wr_data),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(rd0)
    );
    cas_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram1 (
        .aclk(aclk), .we(cmd.wr_en && (cmd.wr_slot == 2'd1)), .waddr(wr_addr), .wdata(wr_data),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(rd1)
    );
    cas_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram2 (
        .aclk(aclk), .we(cmd.wr_en && (cmd.wr_slot == 2'd2)), .waddr(wr_addr), .wdata(wr_data),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(rd2)
    );

    // row above is the slot before the output row, row below the slot after it
    always_comb begin
        unique case (cmd.out_slot)
            2'd0: begin
                px_above = rd2;
                px_mid = rd0;
                px_below = rd1;
            end
            2'd1: begin
                px_above = rd0;
                px_mid = rd1;
                px_below = rd2;
            end
            default: begin
                px_above = rd1;
                px_mid = rd2;
                px_below = rd0;
            end
        endcase
    end

    assign l_a = luma(px_above);
    assign l_m = luma(px_mid);
    assign l_b = luma(px_below);

    assign contrast = 8'(9'd255 - 9'(max_reg - min_reg));
    assign diff_wide = $signed({2'b00, center_reg, 3'b000}) - $signed({2'b00, sum_reg});
    assign q1 = 21'(num_reg >>> 11);
    assign t_s = 22'(q1) + DIV_OFFSET;
    assign q = prod_reg[42:29];

    always_ff @(posedge aclk) begin
        unique case (cmd.cap)
            CAP_LEFT: begin
                sum_reg <= 11'(l_a) + 11'(l_m) + 11'(l_b);
                min_reg <= min8(min8(l_a, l_m), l_b);
                max_reg <= max8(max8(l_a, l_m), l_b);
            end
            CAP_MID: begin
                sum_reg <= sum_reg + 11'(l_a) + 11'(l_b);
                min_reg <= min8(min_reg, min8(l_a, l_b));
                max_reg <= max8(max_reg, max8(l_a, l_b));
                center_reg <= l_m;
                pix_reg <= px_mid;
            end
            CAP_RIGHT: begin
                sum_reg <= sum_reg + 11'(l_a) + 11'(l_m) + 11'(l_b);
                min_reg <= min8(min_reg, min8(min8(l_a, l_m), l_b));
                max_reg <= max8(max_reg, max8(max8(l_a, l_m), l_b));
            end
            default: ;
        endcase
        if (cmd.step_mul1) begin
            m1_reg <= 20'(sharpness) * 20'(contrast);
            diff_reg <= 12'(diff_wide);
        end
        if (cmd.step_mul2) begin
            num_reg <= 32'($signed({1'b0, m1_reg})) * 32'(diff_reg);
        end
        if (cmd.step_div1) begin
            prod_reg <= 43'(t_s[20:0]) * 43'(DIV255_RECIP);
        end
        if (cmd.step_div2) begin
            delta_reg <= cmd.sharp_en ? $signed(q - DIV_BIAS) : 14'sd0;
        end
    end

    always_comb begin
        logic signed [14:0] v;
        for (int c = 0; c < 3; c++) begin
            v = $signed({7'b0, pix_reg[8*c +: 8]}) + 15'(delta_reg);
            if (v < 0) begin
                ch_out[c] = 8'd0;
            end else if (v > 15'sd255) begin
                ch_out[c] = 8'd255;
            end else begin
                ch_out[c] = v[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {pix_reg[31:24], ch_out[2], ch_out[1], ch_out[0]};
            out_last_reg <= cmd.frame_end;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;
    assign m_last = out_last_reg;

endmodule

// File: src/contrast_adaptive_sharpen_top.sv
// a pixel that releases no result is written to its row store and the controller stays idle;
// an item that releases a result passes three row store reads, a capture, the multiply and
// divide-by-constant steps and waits for a free output register, taking no new item meanwhile
// reset: aresetn low at a clock edge clears counters, pending count, output valid and config
// to sharpness 0, width 1920, height 1080; row stores are not cleared
module contrast_adaptive_sharpen_top
    import cas_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // red_in, green_in, blue_in, alpha_in
    input  logic                  s_tuser,  // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                  m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);

    cas_cmd_t           cmd;
    cas_status_t        status;
    logic [CW-1:0]      wr_addr;
    logic [CW-1:0]      rd_addr;
    logic [SHARP_W-1:0] sharpness;

    cas_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_tvalid),
        .s_kind(s_tuser),
        .s_ready(s_tready),
        .status(status),
        .cmd(cmd),
        .wr_addr(wr_addr),
        .rd_addr(rd_addr),
        .sharpness(sharpness)
    );

    cas_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd(cmd),
        .status(status),
        .wr_addr(wr_addr),
        .rd_addr(rd_addr),
        .wr_data(s_tdata),
        .sharpness(sharpness),
        .m_ready(m_tready),
        .m_valid(m_tvalid),
        .m_data(m_tdata),
        .m_last(m_tlast)
    );

endmodule
